// ===== hw/rtl/gdi_pkg.sv =====
`default_nettype none

package gdi_pkg;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } date_t;

    // First stage of the weekday sum: shifted year and the reciprocal products.
    typedef struct packed {
        date_t       date;
        logic [14:0] shifted_year;
        logic [5:0]  month_term;
        logic [26:0] shifted_prod;
        logic [26:0] year_prod;
    } split_t;

    typedef struct packed {
        date_t       date;
        logic [15:0] week_sum;
        logic        leap;
    } sum_t;

    typedef struct packed {
        date_t       date;
        logic [15:0] week_sum;
        logic [28:0] week_prod;
        logic        leap;
        logic [4:0]  month_len;
        logic [8:0]  day_of_year;
    } cal_t;

    localparam logic [14:0] YEAR_OFFSET  = 15'd400;
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;
    localparam logic [14:0] DIV7_MUL     = 15'd18725;
    localparam int          DIV7_SHIFT   = 17;
    localparam logic [8:0]  DAYS_COMMON  = 9'd365;
    localparam logic [8:0]  DAYS_LEAP    = 9'd366;
    localparam logic [3:0]  MONTH_JAN    = 4'd1;
    localparam logic [3:0]  MONTH_FEB    = 4'd2;
    localparam logic [3:0]  MONTH_MAR    = 4'd3;
    localparam logic [3:0]  MONTH_DEC    = 4'd12;

    // (31 * shifted month) / 12, indexed by the calendar month.
    function automatic logic [5:0] month_term(input logic [3:0] m);
        logic [5:0] t;
        unique case (m)
            4'd0:  t = 6'd25;
            4'd1:  t = 6'd28;
            4'd2:  t = 6'd31;
            4'd3:  t = 6'd2;
            4'd4:  t = 6'd5;
            4'd5:  t = 6'd7;
            4'd6:  t = 6'd10;
            4'd7:  t = 6'd12;
            4'd8:  t = 6'd15;
            4'd9:  t = 6'd18;
            4'd10: t = 6'd20;
            4'd11: t = 6'd23;
            4'd12: t = 6'd25;
            4'd13: t = 6'd28;
            4'd14: t = 6'd31;
            4'd15: t = 6'd33;
            default: t = 6'd0;
        endcase
        return t;
    endfunction

    // Days in the months before m of a common year; months past December add nothing.
    function automatic logic [8:0] month_cum(input logic [3:0] m);
        logic [8:0] c;
        unique case (m)
            4'd0:  c = 9'd0;
            4'd1:  c = 9'd0;
            4'd2:  c = 9'd31;
            4'd3:  c = 9'd59;
            4'd4:  c = 9'd90;
            4'd5:  c = 9'd120;
            4'd6:  c = 9'd151;
            4'd7:  c = 9'd181;
            4'd8:  c = 9'd212;
            4'd9:  c = 9'd243;
            4'd10: c = 9'd273;
            4'd11: c = 9'd304;
            4'd12: c = 9'd334;
            default: c = 9'd365;
        endcase
        return c;
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] n;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
            4'd2:                                       n = leap ? 5'd29 : 5'd28;
            default:                                    n = 5'd0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gdi_sum.sv =====
`default_nettype none

module gdi_sum
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire gdi_pkg::date_t in_date,
    output logic               out_valid,
    input  wire logic          out_ready,
    output gdi_pkg::sum_t      out_sum
);
    import gdi_pkg::*;

    logic        split_valid_reg;
    split_t      split_reg;
    split_t      split_next;
    logic        split_ready;
    logic        sum_valid_reg;
    sum_t        sum_reg;
    sum_t        sum_next;
    logic        early_month;
    logic [27:0] shifted_prod_full;
    logic [27:0] year_prod_full;
    logic [7:0]  shifted_q100;
    logic [7:0]  year_q100;
    logic [14:0] year_hundreds;
    logic        century;

    assign split_ready = !sum_valid_reg || out_ready;
    assign in_ready    = !split_valid_reg || split_ready;

    // January and February count as months of the previous year.
    always_comb
    begin
        early_month               = (in_date.month <= MONTH_FEB);
        split_next.date           = in_date;
        split_next.shifted_year   = 15'(in_date.year) + YEAR_OFFSET - 15'(early_month);
        split_next.month_term     = month_term(in_date.month);
        shifted_prod_full         = 28'(split_next.shifted_year) * 28'(DIV100_MUL);
        year_prod_full            = 28'(in_date.year) * 28'(DIV100_MUL);
        split_next.shifted_prod   = shifted_prod_full[26:0];
        split_next.year_prod      = year_prod_full[26:0];
    end

    // The reciprocal products give exact quotients by 100; by 400 is two more shifts.
    always_comb
    begin
        shifted_q100  = split_reg.shifted_prod[DIV100_SHIFT +: 8];
        year_q100     = split_reg.year_prod[DIV100_SHIFT +: 8];
        year_hundreds = 15'({year_q100, 6'b0}) + 15'({year_q100, 5'b0})
                      + 15'({year_q100, 2'b0});
        century       = (15'(split_reg.date.year) == year_hundreds);
        sum_next.date = split_reg.date;
        sum_next.leap = ((split_reg.date.year[1:0] == 2'b00) && !century)
                      || (century && (year_q100[1:0] == 2'b00));
        sum_next.week_sum = 16'(split_reg.date.day) + 16'(split_reg.shifted_year)
                          + 16'(split_reg.shifted_year[14:2]) - 16'(shifted_q100)
                          + 16'(shifted_q100[7:2]) + 16'(split_reg.month_term);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            split_valid_reg <= 1'b0;
            sum_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                split_valid_reg <= in_valid;
            end
            if (split_ready)
            begin
                sum_valid_reg <= split_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            split_reg <= split_next;
        end
        if (split_ready && split_valid_reg)
        begin
            sum_reg <= sum_next;
        end
    end

    assign out_valid = sum_valid_reg;
    assign out_sum   = sum_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/gdi_cal.sv =====
`default_nettype none

module gdi_cal
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire gdi_pkg::sum_t in_sum,
    output logic              out_valid,
    input  wire logic         out_ready,
    output gdi_pkg::cal_t     out_cal
);
    import gdi_pkg::*;

    logic        cal_valid_reg;
    cal_t        cal_reg;
    cal_t        cal_next;
    logic [30:0] week_prod_full;

    assign in_ready = !cal_valid_reg || out_ready;

    always_comb
    begin
        week_prod_full       = 31'(in_sum.week_sum) * 31'(DIV7_MUL);
        cal_next.date        = in_sum.date;
        cal_next.week_sum    = in_sum.week_sum;
        cal_next.week_prod   = week_prod_full[28:0];
        cal_next.leap        = in_sum.leap;
        cal_next.month_len   = month_days(in_sum.date.month, in_sum.leap);
        // A leap day is already behind every month from March on.
        cal_next.day_of_year = 9'(in_sum.date.day) + month_cum(in_sum.date.month)
                             + 9'(in_sum.leap && (in_sum.date.month >= MONTH_MAR));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            cal_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            cal_reg <= cal_next;
        end
    end

    assign out_valid = cal_valid_reg;
    assign out_cal   = cal_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/gregorian_date_info.sv =====
`default_nettype none

// Gregorian date information. Each item on the slave stream is a date; the
// master stream returns one item per date with the weekday, weekend flags,
// leap-year flag, month length, day of the year, the remaining days of the
// week, month and year, and the following date. The block keeps no state.
// It takes one date per clock while no stall from m_tready reaches it, and
// each date passes the stages in order: two stages form the weekday sum and
// the leap flag from reciprocal multiplications by 100, one stage multiplies
// for the modulo 7 and looks up the month tables, and the output register
// finishes the remainders and the next date. Each stage holds one item and
// stalls only when the stage after it is full, so earlier stages keep
// accepting while a result waits on m_tready.
module gregorian_date_info
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // day [4:0], month [8:5], year [22:9], zero [23]
    input  wire logic [23:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // weekday [2:0], is_saturday [3], is_weekend [4], leap_year [5],
    // month_length [10:6], day_of_year [19:11], days_to_week_end [22:20],
    // days_to_month_end [27:23], days_to_year_end [36:28], next_day [41:37],
    // next_month [45:42], next_year [59:46], zero [63:60]
    output logic [63:0]      m_tdata
);
    import gdi_pkg::*;

    date_t       in_date;
    logic        sum_valid;
    logic        sum_ready;
    sum_t        sum_item;
    logic        cal_valid;
    logic        cal_ready;
    cal_t        cal_item;
    logic        out_valid_reg;
    logic [63:0] out_reg;
    logic [63:0] out_next;
    logic [11:0] week_q;
    logic [15:0] week_rem;
    logic [2:0]  weekday;
    logic [8:0]  year_len;
    logic [8:0]  to_year;
    logic [5:0]  len_plus;
    logic [5:0]  to_month_wide;
    logic [4:0]  to_month;
    logic [4:0]  next_day;
    logic [3:0]  next_month;
    logic [13:0] next_year;

    assign in_date.day   = s_tdata[4:0];
    assign in_date.month = s_tdata[8:5];
    assign in_date.year  = s_tdata[22:9];

    gdi_sum u_sum
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_date   (in_date),
        .out_valid (sum_valid),
        .out_ready (sum_ready),
        .out_sum   (sum_item)
    );

    gdi_cal u_cal
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sum_valid),
        .in_ready  (sum_ready),
        .in_sum    (sum_item),
        .out_valid (cal_valid),
        .out_ready (cal_ready),
        .out_cal   (cal_item)
    );

    assign cal_ready = !out_valid_reg || m_tready;

    always_comb
    begin
        week_q   = cal_item.week_prod[DIV7_SHIFT +: 12];
        week_rem = cal_item.week_sum - 16'({week_q, 3'b0}) + 16'(week_q);
        weekday  = week_rem[2:0];

        year_len = cal_item.leap ? DAYS_LEAP : DAYS_COMMON;
        to_year  = (cal_item.day_of_year > year_len) ? 9'd0
                                                     : year_len - cal_item.day_of_year;

        // Today counts, so a day past the month end saturates at zero.
        len_plus      = 6'(cal_item.month_len) + 6'd1;
        to_month_wide = (6'(cal_item.date.day) > len_plus) ? 6'd0
                                                           : len_plus - 6'(cal_item.date.day);
        to_month      = to_month_wide[5] ? 5'd31 : to_month_wide[4:0];

        if (cal_item.date.day >= cal_item.month_len)
        begin
            next_day = 5'd1;
            if (cal_item.date.month >= MONTH_DEC)
            begin
                next_month = MONTH_JAN;
                next_year  = cal_item.date.year + 14'd1;
            end
            else
            begin
                next_month = cal_item.date.month + 4'd1;
                next_year  = cal_item.date.year;
            end
        end
        else
        begin
            next_day   = cal_item.date.day + 5'd1;
            next_month = cal_item.date.month;
            next_year  = cal_item.date.year;
        end

        out_next = {4'b0, next_year, next_month, next_day, to_year, to_month,
                    3'd6 - weekday, cal_item.day_of_year, cal_item.month_len,
                    cal_item.leap, (weekday == 3'd5) || (weekday == 3'd6),
                    (weekday == 3'd6), weekday};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cal_ready)
        begin
            out_valid_reg <= cal_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cal_ready && cal_valid)
        begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    // With the output register empty every stage can move, so the input is ready.
    assert property (@(posedge clk) disable iff (!rst_n) !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output register");

    // The modulo 7 correction must leave a weekday below seven.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2:0] != 3'd7))
        else $error("weekday out of range");

    // Weekday and days to the week end always add up to six.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((4'(m_tdata[2:0]) + 4'(m_tdata[22:20])) == 4'd6))
        else $error("weekday and days to week end disagree");

    // A result that is not taken stays in place.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("output changed while stalled");

endmodule

`default_nettype wire

// ===== tb/gregorian_date_info_tb.sv =====
`timescale 1ns / 100ps

module gregorian_date_info_tb;
    import gdi_pkg::*;

    localparam int CLK_PERIOD  = 20;
    localparam int RESET_TICKS = 6;
    localparam int RANDOM_SETS = 8;
    localparam int SET_ITEMS   = 94;
    localparam int DRAIN_TICKS = 12;
    localparam int MAX_REPORTS = 10;

    typedef enum {FREE_RUN, SEND_GAPS, RECV_STALLS, BOTH_GAPS} flow_mode_e;

    // Mirrors the master tdata layout, weekday in the lowest bits.
    typedef struct packed {
        logic [3:0]  pad;
        logic [13:0] next_year;
        logic [3:0]  next_month;
        logic [4:0]  next_day;
        logic [8:0]  days_to_year_end;
        logic [4:0]  days_to_month_end;
        logic [2:0]  days_to_week_end;
        logic [8:0]  day_of_year;
        logic [4:0]  month_length;
        logic        leap_year;
        logic        is_weekend;
        logic        is_saturday;
        logic [2:0]  weekday;
    } date_info_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;

    date_t      pending_dates[$];
    date_info_t expected_info_q[$];
    date_info_t want;
    flow_mode_e flow_mode;
    bit         took_item;
    int         mismatches;

    gregorian_date_info dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic logic leap_of_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned days_in_month(input int unsigned m, input logic leap);
        int unsigned n;
        case (m)
            1, 3, 5, 7, 8, 10, 12: n = 31;
            4, 6, 9, 11:           n = 30;
            2:                     n = leap ? 29 : 28;
            default:               n = 0;
        endcase
        return n;
    endfunction

    function automatic date_info_t predict_date_info(input date_t dt);
        int unsigned d, m, y, early, yy, mm, wd, len, doy, ylen, left, i;
        logic        leap;
        date_info_t  r;
        d = 32'(dt.day);
        m = 32'(dt.month);
        y = 32'(dt.year);
        // January and February count as months 11 and 12 of the year before.
        early = (m <= 2) ? 1 : 0;
        yy = y + 400 - early;
        mm = m + 12 * early - 2;
        wd = (d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
        leap = leap_of_year(y);
        len = days_in_month(m, leap);
        doy = d;
        for (i = 1; i < m; i++)
        begin
            doy += days_in_month(i, leap);
        end
        ylen = leap ? 366 : 365;
        r = '0;
        r.weekday = 3'(wd);
        r.is_saturday = (wd == 6);
        r.is_weekend = (wd == 5) || (wd == 6);
        r.leap_year = leap;
        r.month_length = 5'(len);
        r.day_of_year = 9'(doy);
        r.days_to_week_end = 3'(6 - wd);
        left = (d > len + 1) ? 0 : len + 1 - d;
        r.days_to_month_end = 5'((left > 31) ? 31 : left);
        r.days_to_year_end = 9'((doy > ylen) ? 0 : ylen - doy);
        if (d >= len)
        begin
            r.next_day = 5'd1;
            r.next_month = 4'((m >= 12) ? 1 : m + 1);
            r.next_year = 14'((m >= 12) ? y + 1 : y);
        end
        else
        begin
            r.next_day = 5'(d + 1);
            r.next_month = 4'(m);
            r.next_year = 14'(y);
        end
        return r;
    endfunction

    function automatic bit sender_idle();
        case (flow_mode)
            SEND_GAPS: return $urandom_range(99) < 53;
            BOTH_GAPS: return $urandom_range(99) < 31;
            default:   return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stall();
        case (flow_mode)
            RECV_STALLS: return $urandom_range(99) < 53;
            BOTH_GAPS:   return $urandom_range(99) < 31;
            default:     return 1'b0;
        endcase
    endfunction

    task automatic queue_date(input int unsigned d, input int unsigned m, input int unsigned y);
        date_t x;
        x.day = 5'(d);
        x.month = 4'(m);
        x.year = 14'(y);
        pending_dates.push_back(x);
    endtask

    // Mostly valid dates weighted towards century years and month ends, with
    // some raw field noise that reaches the out-of-range months and days.
    task automatic queue_random_date();
        date_t       x;
        int unsigned kind, len;
        kind = $urandom_range(99);
        if (kind < 15)
        begin
            x.day = 5'($urandom_range(31));
            x.month = 4'($urandom_range(15));
            x.year = 14'($urandom_range(16383));
        end
        else
        begin
            kind = $urandom_range(9);
            if (kind < 5)
                x.year = 14'($urandom_range(1, 9999));
            else if (kind < 7)
                x.year = 14'(400 * $urandom_range(1, 24));
            else if (kind < 8)
                x.year = 14'(100 * $urandom_range(1, 99));
            else if (kind < 9)
                x.year = 14'(4 * $urandom_range(1, 2499));
            else
                x.year = 14'($urandom_range(1) ? $urandom_range(1, 3)
                                               : $urandom_range(9996, 9999));
            x.month = 4'($urandom_range(1, 12));
            len = days_in_month(32'(x.month), leap_of_year(32'(x.year)));
            x.day = 5'(($urandom_range(2) == 0) ? len - $urandom_range(1)
                                                : $urandom_range(1, len));
        end
        pending_dates.push_back(x);
    endtask

    // Holds the test sequence back until every queued item has been taken and answered.
    task automatic wait_drained();
        while (pending_dates.size() != 0 || s_tvalid || expected_info_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        took_item = 1'b0;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                took_item = 1'b1;
                expected_info_q.push_back(predict_date_info(date_t'(s_tdata[22:0])));
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_info_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("Unexpected result item %h at %0t", m_tdata, $realtime);
                end
                else
                begin
                    want = expected_info_q.pop_front();
                    if (m_tdata !== want)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("Result mismatch at %0t\n  expected %p\n  actual   %p",
                                     $realtime, want, date_info_t'(m_tdata));
                    end
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || took_item)
            begin
                if (pending_dates.size() != 0 && !sender_idle())
                begin
                    s_tdata <= {1'b0, pending_dates.pop_front()};
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= !receiver_stall();
        end
    end

    initial
    begin
        #(CLK_PERIOD * 200000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        mismatches = 0;
        flow_mode = FREE_RUN;
        repeat (RESET_TICKS) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        queue_date(1, 1, 1);
        queue_date(31, 12, 9999);
        queue_date(31, 12, 16383);      // year wraps to zero
        queue_date(0, 0, 0);
        queue_date(1, 1, 0);
        queue_date(1, 3, 1);
        queue_date(28, 2, 2023);
        queue_date(28, 2, 2024);
        queue_date(29, 2, 2024);
        queue_date(29, 2, 1900);
        queue_date(29, 2, 2000);
        queue_date(31, 2, 2001);
        queue_date(30, 4, 2021);
        queue_date(31, 4, 2021);
        queue_date(15, 0, 2020);
        queue_date(10, 13, 2020);
        queue_date(5, 14, 100);
        queue_date(31, 15, 16383);
        queue_date(31, 1, 400);
        queue_date(0, 6, 1999);
        queue_date(31, 12, 2024);
        queue_date(31, 12, 2023);
        queue_date(16, 8, 8191);
        wait_drained();

        for (int set = 0; set < RANDOM_SETS; set++)
        begin
            flow_mode = flow_mode_e'(set % 4);
            for (int n = 0; n < SET_ITEMS; n++)
            begin
                queue_random_date();
            end
            wait_drained();
        end

        repeat (DRAIN_TICKS) @(posedge clk);
        if (mismatches == 0 && expected_info_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/gdi_pkg.sv
hw/rtl/gdi_sum.sv
hw/rtl/gdi_cal.sv
hw/rtl/gregorian_date_info.sv
tb/gregorian_date_info_tb.sv
